// File: rtl/core/tqm_pkg.sv
// Shared constants and helpers for the TRS quaternion-to-matrix pipeline.
// Used by every module under rtl/core; depends on nothing.
package tqm_pkg;

  localparam int Q_W        = 32;               // Q16.16 word
  localparam int PROD_W     = 2 * Q_W;          // exact component product
  localparam int NORM_W     = PROD_W + 1;       // squared norm
  localparam int FRAC_STEPS = 18;               // fraction bits of the ratio
  localparam int DIV_STG    = FRAC_STEPS + 1;   // integer step plus fraction steps
  localparam int QUO_W      = FRAC_STEPS + 1;   // quotient width
  localparam int ROT_W      = 19;               // signed rotation entry
  localparam int MUL_W      = ROT_W + Q_W;      // rotation times scale
  localparam int LANES      = 9;                // rotation entries
  localparam int FRONT_STG  = 3;
  localparam int DIVR_STG   = DIV_STG + 1;      // divider steps plus rounding
  localparam int SCALE_STG  = 2;
  localparam int NSTG       = FRONT_STG + DIVR_STG + SCALE_STG;
  localparam int Q_ONE      = 65536;

  typedef logic [PROD_W-1:0] mag_t;
  typedef logic [NORM_W-1:0] norm_t;
  typedef logic signed [ROT_W-1:0] rot_t;

  // Diagonal entries of the column-major 3x3 rotation sit at indexes 0, 4 and 8.
  function automatic logic is_diag(input int lane);
    return (lane % 4) == 0;
  endfunction

endpackage

// File: rtl/core/trs_quaternion_to_matrix.sv
// TRS quaternion-to-matrix: 25 register stages, so a transform accepted at the input
// passes through every stage in order before it can leave as an output transfer.
// Throughput is one transform per cycle while the output is not stalled; the 19-step pipelined divider sets the depth.
// rst (synchronous, active high) clears every stage valid bit; data registers hold.
// Each stage advances when it is empty or the stage after it advances, so bubbles
// collapse and a stalled output loses and repeats nothing.
module trs_quaternion_to_matrix import tqm_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z, scale_x, scale_y, scale_z
  input  logic [319:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // col0_x, col0_y, col0_z, col1_x, col1_y, col1_z, col2_x, col2_y, col2_z,
  // trans_x, trans_y, trans_z
  output logic [383:0] m_axis_tdata
);

  localparam int SCALE_TAP = FRONT_STG + DIVR_STG - 1;

  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] en;

  // Position and scale ride alongside the arithmetic, one register per stage.
  logic [3*Q_W-1:0] pos_pipe [NSTG];
  logic [3*Q_W-1:0] scl_pipe [NSTG];

  mag_t  [LANES-1:0]          mag;
  logic  [LANES-1:0]          neg;
  norm_t                      norm;
  rot_t  [LANES-1:0]          rot;
  logic  [LANES-1:0][Q_W-1:0] ent;

  // Ready ripples back from the output: a stage may load when it is empty
  // or its contents move on in the same cycle.
  always_comb begin
    en[NSTG-1] = !vld[NSTG-1] || m_axis_tready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pos_pipe[0] <= s_axis_tdata[95:0];
      scl_pipe[0] <= s_axis_tdata[319:224];
    end
    for (int k = 1; k < NSTG; k++) begin
      if (en[k]) begin
        pos_pipe[k] <= pos_pipe[k-1];
        scl_pipe[k] <= scl_pipe[k-1];
      end
    end
  end

  tqm_front u_front (
    .clk    (clk),
    .en     (en[FRONT_STG-1:0]),
    .quat_w (s_axis_tdata[127:96]),
    .quat_x (s_axis_tdata[159:128]),
    .quat_y (s_axis_tdata[191:160]),
    .quat_z (s_axis_tdata[223:192]),
    .mag    (mag),
    .neg    (neg),
    .norm   (norm)
  );

  tqm_divider u_div (
    .clk  (clk),
    .en   (en[FRONT_STG+DIVR_STG-1:FRONT_STG]),
    .mag  (mag),
    .neg  (neg),
    .norm (norm),
    .rot  (rot)
  );

  tqm_scale u_scale (
    .clk     (clk),
    .en      (en[NSTG-1:NSTG-SCALE_STG]),
    .rot     (rot),
    .scale_x (scl_pipe[SCALE_TAP][31:0]),
    .scale_y (scl_pipe[SCALE_TAP][63:32]),
    .scale_z (scl_pipe[SCALE_TAP][95:64]),
    .ent     (ent)
  );

  // Entries already come out column by column, in the order of the port.
  assign m_axis_tdata = {pos_pipe[NSTG-1],
                         ent[8], ent[7], ent[6],
                         ent[5], ent[4], ent[3],
                         ent[2], ent[1], ent[0]};

  // No transfer is taken while reset is held.
  assign s_axis_tready = en[0] && !rst;
  assign m_axis_tvalid = vld[NSTG-1];

endmodule

// File: rtl/core/tqm_front.sv
// Front end: component products, pairwise sums, squared norm and sign/magnitude split.
// Depends on tqm_pkg.
module tqm_front import tqm_pkg::*; (
  input  logic                        clk,
  input  logic [FRONT_STG-1:0]        en,
  input  logic signed [Q_W-1:0]       quat_w,
  input  logic signed [Q_W-1:0]       quat_x,
  input  logic signed [Q_W-1:0]       quat_y,
  input  logic signed [Q_W-1:0]       quat_z,
  output mag_t  [LANES-1:0]           mag,
  output logic  [LANES-1:0]           neg,
  output norm_t                       norm
);

  logic [Q_W-1:0] aw, ax, ay, az;
  mag_t ww, xx, yy, zz, xy, xz, yz, wx, wy, wz;
  mag_t t0, t1, t2, s1, s2, s3, s5, s6, s7;
  norm_t n01, n23;
  mag_t  u [LANES];

  assign aw = quat_w[Q_W-1] ? Q_W'(-quat_w) : quat_w;
  assign ax = quat_x[Q_W-1] ? Q_W'(-quat_x) : quat_x;
  assign ay = quat_y[Q_W-1] ? Q_W'(-quat_y) : quat_y;
  assign az = quat_z[Q_W-1] ? Q_W'(-quat_z) : quat_z;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ww <= PROD_W'(aw) * PROD_W'(aw);
      xx <= PROD_W'(ax) * PROD_W'(ax);
      yy <= PROD_W'(ay) * PROD_W'(ay);
      zz <= PROD_W'(az) * PROD_W'(az);
      xy <= mag_t'(PROD_W'(quat_x) * PROD_W'(quat_y));
      xz <= mag_t'(PROD_W'(quat_x) * PROD_W'(quat_z));
      yz <= mag_t'(PROD_W'(quat_y) * PROD_W'(quat_z));
      wx <= mag_t'(PROD_W'(quat_w) * PROD_W'(quat_x));
      wy <= mag_t'(PROD_W'(quat_w) * PROD_W'(quat_y));
      wz <= mag_t'(PROD_W'(quat_w) * PROD_W'(quat_z));
    end
  end

  // Signed products above are formed on sign-extended operands so the low
  // 64 bits are the exact two's complement product.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      n01 <= {1'b0, ww} + {1'b0, xx};
      n23 <= {1'b0, yy} + {1'b0, zz};
      t0  <= yy + zz;
      t1  <= xx + zz;
      t2  <= xx + yy;
      s1  <= xy + wz;
      s2  <= xz - wy;
      s3  <= xy - wz;
      s5  <= yz + wx;
      s6  <= xz + wy;
      s7  <= yz - wx;
    end
  end

  always_comb begin
    u[0] = t0; u[1] = s1; u[2] = s2; u[3] = s3; u[4] = t1;
    u[5] = s5; u[6] = s6; u[7] = s7; u[8] = t2;
  end

  // The sum 2^63 is a positive magnitude, not the most negative value.
  always_ff @(posedge clk) begin
    if (en[2]) begin
      norm <= n01 + n23;
      for (int i = 0; i < LANES; i++) begin
        if (!is_diag(i) && u[i][PROD_W-1] && (u[i] != {1'b1, {(PROD_W-1){1'b0}}})) begin
          neg[i] <= 1'b1;
          mag[i] <= mag_t'(-u[i]);
        end else begin
          neg[i] <= 1'b0;
          mag[i] <= u[i];
        end
      end
    end
  end

endmodule

// File: rtl/core/tqm_divider.sv
// Pipelined restoring divider for the nine normalized entries, one quotient bit
// per stage, followed by rounding to signed rotation entries. Depends on tqm_pkg.
module tqm_divider import tqm_pkg::*; (
  input  logic                  clk,
  input  logic [DIVR_STG-1:0]   en,
  input  mag_t  [LANES-1:0]     mag,
  input  logic  [LANES-1:0]     neg,
  input  norm_t                 norm,
  output rot_t  [LANES-1:0]     rot
);

  mag_t  rem [DIV_STG][LANES];
  logic [QUO_W-1:0] quo [DIV_STG][LANES];
  logic [LANES-1:0] sgn [DIV_STG];
  norm_t nrm [DIV_STG];

  // Integer step: the magnitude never exceeds the norm, so one compare suffices.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      nrm[0] <= norm;
      sgn[0] <= neg;
      for (int i = 0; i < LANES; i++) begin
        if ({1'b0, mag[i]} >= norm) begin
          quo[0][i] <= QUO_W'(1);
          rem[0][i] <= mag_t'({1'b0, mag[i]} - norm);
        end else begin
          quo[0][i] <= '0;
          rem[0][i] <= mag[i];
        end
      end
    end
  end

  for (genvar s = 1; s < DIV_STG; s++) begin : g_step
    always_ff @(posedge clk) begin
      if (en[s]) begin
        nrm[s] <= nrm[s-1];
        sgn[s] <= sgn[s-1];
        for (int i = 0; i < LANES; i++) begin
          if ({rem[s-1][i], 1'b0} >= nrm[s-1]) begin
            rem[s][i] <= mag_t'({rem[s-1][i], 1'b0} - nrm[s-1]);
            quo[s][i] <= {quo[s-1][i][QUO_W-2:0], 1'b1};
          end else begin
            rem[s][i] <= {rem[s-1][i][PROD_W-2:0], 1'b0};
            quo[s][i] <= {quo[s-1][i][QUO_W-2:0], 1'b0};
          end
        end
      end
    end
  end

  logic [QUO_W:0] half [LANES];
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      half[i] = ({1'b0, quo[DIV_STG-1][i]} + (QUO_W+1)'(1)) >> 1;
    end
  end

  // A zero norm means a zero quaternion, which maps to the identity.
  always_ff @(posedge clk) begin
    if (en[DIVR_STG-1]) begin
      for (int i = 0; i < LANES; i++) begin
        if (nrm[DIV_STG-1] == '0) begin
          rot[i] <= is_diag(i) ? rot_t'(Q_ONE) : '0;
        end else if (is_diag(i)) begin
          rot[i] <= rot_t'(Q_ONE) - rot_t'(half[i]);
        end else if (sgn[DIV_STG-1][i]) begin
          rot[i] <= -rot_t'(half[i]);
        end else begin
          rot[i] <= rot_t'(half[i]);
        end
      end
    end
  end

endmodule

// File: rtl/core/tqm_scale.sv
// Multiplies each rotation entry by its column's scale, rounds to Q16.16 and
// saturates. Depends on tqm_pkg.
module tqm_scale import tqm_pkg::*; (
  input  logic                      clk,
  input  logic [SCALE_STG-1:0]      en,
  input  rot_t  [LANES-1:0]         rot,
  input  logic signed [Q_W-1:0]     scale_x,
  input  logic signed [Q_W-1:0]     scale_y,
  input  logic signed [Q_W-1:0]     scale_z,
  output logic  [LANES-1:0][Q_W-1:0] ent
);

  localparam int SH_W = MUL_W - 16;

  logic signed [MUL_W-1:0] prod [LANES];
  logic signed [Q_W-1:0]   scl  [LANES];
  logic signed [SH_W-1:0]  rnd  [LANES];

  // Entries are column-major; entries 3c to 3c+2 form column c and take scale c.
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      unique case (i / 3)
        0:       scl[i] = scale_x;
        1:       scl[i] = scale_y;
        default: scl[i] = scale_z;
      endcase
      rnd[i] = SH_W'((prod[i] + MUL_W'(32768)) >>> 16);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < LANES; i++) begin
        prod[i] <= MUL_W'(rot[i]) * MUL_W'(scl[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < LANES; i++) begin
        if (rnd[i] > SH_W'(32'sh7fffffff)) begin
          ent[i] <= 32'h7fffffff;
        end else if (rnd[i] < -SH_W'(33'sh080000000)) begin
          ent[i] <= 32'h80000000;
        end else begin
          ent[i] <= rnd[i][Q_W-1:0];
        end
      end
    end
  end

endmodule
